// File: hdl/mmh64a_pkg.sv
// Shared constants, types and command/status structs for the MurmurHash64A engine.
package mmh64a_pkg;

  // Hash constants
  localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;

  // Field widths
  localparam int LEN_W  = 31;
  localparam int WORD_W = 64;
  localparam int VB_W   = 4;
  localparam int HASH_W = 64;
  localparam int BYTES  = WORD_W / 8;

  // Partial-product step codes of the shared 32x32 multiplier
  localparam logic [1:0] STEP_LL = 2'd0;  // low operand x low constant
  localparam logic [1:0] STEP_LH = 2'd1;  // low operand x high constant
  localparam logic [1:0] STEP_HL = 2'd2;  // high operand x low constant

  // Last count value of a multiply state (operand load plus three steps)
  localparam logic [1:0] CNT_LAST = 2'd3;
  localparam logic [1:0] CNT_LOAD = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LEN_MUL,
    ST_SEED_WB,
    ST_KEY_MUL1,
    ST_KEY_MUL2,
    ST_HASH_MUL,
    ST_HASH_WB,
    ST_AVAL_MUL,
    ST_RESULT
  } ctl_state_t;

  typedef enum logic [2:0] {
    OPND_LEN,
    OPND_WORD,
    OPND_KMIX,
    OPND_BMIX,
    OPND_TAIL,
    OPND_AVAL
  } opnd_sel_t;

  typedef struct packed {
    logic       capture;
    logic       opnd_load;
    opnd_sel_t  opnd_sel;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       seed_wb;
    logic       hash_wb;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full_blk;
    logic tail_nz;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/mmh64a_in_if.sv
// Input word channel: valid/ready handshake with the key word payload.
interface mmh64a_in_if;
  logic        valid;
  logic        ready;
  logic        first_word;
  logic [30:0] key_length;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, output first_word, output key_length, output data_word,
                  output valid_bytes, output last_word, input ready);
  modport sink   (input valid, input first_word, input key_length, input data_word,
                  input valid_bytes, input last_word, output ready);
endinterface

// File: hdl/mmh64a_out_if.sv
// Result channel: valid/ready handshake carrying the final hash.
interface mmh64a_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// File: hdl/mmh64a_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the seed.
interface mmh64a_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_seed;

  modport source (output valid, output hash_seed, input ready);
  modport sink   (input valid, input hash_seed, output ready);
endinterface

// File: hdl/murmur_hash_64a.sv
// Per word: a length multiply if first; key and hash multiplies if full or not last, else a hash
// multiply for a nonzero tail; an avalanche multiply if last. in_ready is high only when idle.
// Each 64-bit multiply runs on the single shared 32x32 multiplier (load + 3 products).
// The hash is registered after the avalanche multiply once the output is free; it waits for out_ready.
// Reset (synchronous, rst_n low): seed and running hash clear to 0, controller returns to idle.
module murmur_hash_64a (
  input  logic         clk,
  input  logic         rst_n,
  mmh64a_in_if.sink    in_chan,
  mmh64a_out_if.source out_chan,
  mmh64a_cfg_if.sink   cfg_chan
);
  import mmh64a_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // Seed writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  mmh64a_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmh64a_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_first_word  (in_chan.first_word),
    .in_key_length  (in_chan.key_length),
    .in_data_word   (in_chan.data_word),
    .in_valid_bytes (in_chan.valid_bytes),
    .in_last_word   (in_chan.last_word),
    .cfg_we         (cfg_chan.valid),
    .cfg_seed       (cfg_chan.hash_seed),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_hash       (out_chan.hash_value)
  );

  // A word in progress blocks the next transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input accepted while a word was still in progress");

  // Results come only from last words
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.last)
    else $error("result loaded for a word that is not last");

  // Never overwrite a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten before its transaction");

  // A loaded result is offered next cycle
  a_result_offered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_chan.valid)
    else $error("loaded result not offered");

endmodule

// File: hdl/mmh64a_ctl.sv
// Sequencing state machine: issues datapath commands for each input word.
module mmh64a_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mmh64a_pkg::dp_stat_t stat,
  output mmh64a_pkg::dp_cmd_t  cmd
);
  import mmh64a_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  ctl_state_t data_next;
  logic       mul_state;
  logic       cnt_done;

  // Pick the data step for the latched word
  always_comb begin
    if (!stat.last || stat.full_blk) begin
      data_next = ST_KEY_MUL1;
    end else if (stat.tail_nz) begin
      data_next = ST_HASH_MUL;
    end else begin
      data_next = ST_AVAL_MUL;
    end
  end

  assign mul_state = (state_r == ST_LEN_MUL) || (state_r == ST_KEY_MUL1) ||
                     (state_r == ST_KEY_MUL2) || (state_r == ST_HASH_MUL) ||
                     (state_r == ST_AVAL_MUL);
  assign cnt_done  = (cnt_r == CNT_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: state_nxt = stat.first ? ST_LEN_MUL : data_next;
      ST_LEN_MUL:  if (cnt_done) state_nxt = ST_SEED_WB;
      ST_SEED_WB:  state_nxt = data_next;
      ST_KEY_MUL1: if (cnt_done) state_nxt = ST_KEY_MUL2;
      ST_KEY_MUL2: if (cnt_done) state_nxt = ST_HASH_MUL;
      ST_HASH_MUL: if (cnt_done) state_nxt = ST_HASH_WB;
      ST_HASH_WB:  state_nxt = stat.last ? ST_AVAL_MUL : ST_IDLE;
      ST_AVAL_MUL: if (cnt_done) state_nxt = ST_RESULT;
      ST_RESULT:   if (stat.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Step counter inside multiply states
  assign cnt_nxt = mul_state ? cnt_r + 2'd1 : CNT_LOAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= CNT_LOAD;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.opnd_sel = OPND_WORD;
    if (mul_state) begin
      cmd.opnd_load = (cnt_r == CNT_LOAD);
      cmd.mul_en    = (cnt_r != CNT_LOAD);
      cmd.mul_step  = cnt_r - 2'd1;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LEN_MUL:  cmd.opnd_sel = OPND_LEN;
      ST_SEED_WB:  cmd.seed_wb  = 1'b1;
      ST_KEY_MUL1: cmd.opnd_sel = OPND_WORD;
      ST_KEY_MUL2: cmd.opnd_sel = OPND_KMIX;
      ST_HASH_MUL: begin
        cmd.opnd_sel = (stat.last && !stat.full_blk) ? OPND_TAIL : OPND_BMIX;
      end
      ST_HASH_WB:  cmd.hash_wb  = 1'b1;
      ST_AVAL_MUL: cmd.opnd_sel = OPND_AVAL;
      ST_RESULT:   cmd.out_load = stat.out_free;
      default:     cmd.opnd_sel = OPND_WORD;
    endcase
  end

endmodule

// File: hdl/mmh64a_dp.sv
// Datapath: word latch, seed, running hash, shared 32x32 multiplier and result register.
module mmh64a_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mmh64a_pkg::dp_cmd_t        cmd,
  output mmh64a_pkg::dp_stat_t       stat,
  input  logic                       in_first_word,
  input  logic [mmh64a_pkg::LEN_W-1:0]  in_key_length,
  input  logic [mmh64a_pkg::WORD_W-1:0] in_data_word,
  input  logic [mmh64a_pkg::VB_W-1:0]   in_valid_bytes,
  input  logic                       in_last_word,
  input  logic                       cfg_we,
  input  logic [mmh64a_pkg::HASH_W-1:0] cfg_seed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mmh64a_pkg::HASH_W-1:0] out_hash
);
  import mmh64a_pkg::*;

  logic              first_r, last_r;
  logic [LEN_W-1:0]  len_r;
  logic [WORD_W-1:0] word_r;
  logic [VB_W-1:0]   vb_r;
  logic [63:0]       seed_r, hash_r, hash_nxt;
  logic [63:0]       opnd_r, opnd_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [63:0]       out_hash_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] tail_mask;
  logic [31:0]       mul_x, mul_y;
  logic [63:0]       mul_p;

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      first_r <= in_first_word;
      last_r  <= in_last_word;
      len_r   <= in_key_length;
      word_r  <= in_data_word;
      vb_r    <= in_valid_bytes;
    end
  end

  // Keep the low valid bytes of a tail word
  always_comb begin
    for (int i = 0; i < BYTES; i++) begin
      tail_mask[i*8 +: 8] = {8{VB_W'(i) < vb_r}};
    end
  end

  // Select the multiplier operand
  always_comb begin
    opnd_nxt = opnd_r;
    if (cmd.opnd_load) begin
      case (cmd.opnd_sel)
        OPND_LEN:  opnd_nxt = {{(64-LEN_W){1'b0}}, len_r};
        OPND_WORD: opnd_nxt = word_r;
        OPND_KMIX: opnd_nxt = prod_r ^ (prod_r >> MIX_SHIFT);
        OPND_BMIX: opnd_nxt = hash_r ^ prod_r;
        OPND_TAIL: opnd_nxt = hash_r ^ (word_r & tail_mask);
        OPND_AVAL: opnd_nxt = hash_r ^ (hash_r >> MIX_SHIFT);
        default:   opnd_nxt = opnd_r;
      endcase
    end
  end

  // One partial product per cycle, low 64 bits kept
  assign mul_x = (cmd.mul_step == STEP_HL) ? opnd_r[63:32] : opnd_r[31:0];
  assign mul_y = (cmd.mul_step == STEP_LH) ? MIX_MULT[63:32] : MIX_MULT[31:0];
  assign mul_p = mul_x * mul_y;

  always_comb begin
    prod_nxt = prod_r;
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        STEP_LL: prod_nxt = mul_p;
        STEP_LH: prod_nxt = prod_r + {mul_p[31:0], 32'h0};
        STEP_HL: prod_nxt = prod_r + {mul_p[31:0], 32'h0};
        default: prod_nxt = prod_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    opnd_r <= opnd_nxt;
    prod_r <= prod_nxt;
  end

  // Write back the running hash
  always_comb begin
    hash_nxt = hash_r;
    if (cmd.seed_wb) begin
      hash_nxt = seed_r ^ prod_r;
    end else if (cmd.hash_wb) begin
      hash_nxt = prod_r;
    end
  end

  // Hold the result until the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hash_r <= prod_r ^ (prod_r >> MIX_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_seed;
      end
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.first    = first_r;
  assign stat.last     = last_r;
  assign stat.full_blk = vb_r[VB_W-1];
  assign stat.tail_nz  = (vb_r[VB_W-2:0] != '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

endmodule

// File: tb/murmur_hash_64a_tb.sv
// Self-checking testbench for the streaming MurmurHash64A engine with its own hash predictor.
`timescale 1ns / 1ps

module murmur_hash_64a_tb;
  import mmh64a_pkg::*;

  localparam logic [63:0] KEY_MULT      = 64'hc6a4a7935bd1e995;
  localparam int          KEY_SHIFT     = 47;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          IDLE_PERCENT  = 23;

  typedef struct {
    logic              first_word;
    logic [LEN_W-1:0]  key_length;
    logic [WORD_W-1:0] data_word;
    logic [VB_W-1:0]   valid_bytes;
    logic              last_word;
  } key_word_t;

  logic clk;
  logic rst_n;

  mmh64a_in_if  in_bus ();
  mmh64a_out_if out_bus ();
  mmh64a_cfg_if cfg_bus ();

  murmur_hash_64a dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Predictor state: seed register and hash before the avalanche
  logic [63:0] seed_shadow;
  logic [63:0] hash_state;
  logic [63:0] expected_hashes[$];

  int error_count;
  bit stall_free;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Fold one full 8-byte block into the running hash
  function automatic logic [63:0] fold_block(input logic [63:0] h, input logic [63:0] k);
    logic [63:0] m;
    m = k * KEY_MULT;
    m = m ^ (m >> KEY_SHIFT);
    m = m * KEY_MULT;
    return (h ^ m) * KEY_MULT;
  endfunction

  // Final avalanche of the running hash
  function automatic logic [63:0] final_mix(input logic [63:0] h);
    logic [63:0] r;
    r = h ^ (h >> KEY_SHIFT);
    r = r * KEY_MULT;
    return r ^ (r >> KEY_SHIFT);
  endfunction

  // Advance the predicted hash by one accepted word; queue the hash on a last word
  function automatic void absorb_word(input key_word_t w);
    logic [63:0] mask;
    int          n;
    n = int'(w.valid_bytes);
    if (w.first_word)
      hash_state = seed_shadow ^ (64'(w.key_length) * KEY_MULT);
    if (!w.last_word || n >= BYTES) begin
      hash_state = fold_block(hash_state, w.data_word);
    end else if (n != 0) begin
      mask = ~64'd0 >> (64 - 8 * n);
      hash_state = (hash_state ^ (w.data_word & mask)) * KEY_MULT;
    end
    if (w.last_word)
      expected_hashes.push_back(final_mix(hash_state));
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic key_word_t make_word(input logic f, input logic [LEN_W-1:0] len,
                                          input logic [63:0] d, input logic [VB_W-1:0] vb,
                                          input logic l);
    key_word_t w;
    w.first_word  = f;
    w.key_length  = len;
    w.data_word   = d;
    w.valid_bytes = vb;
    w.last_word   = l;
    return w;
  endfunction

  // Check each accepted result against the oldest expected hash; drive ready
  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_hashes.size() == 0) begin
        flag_error($sformatf("unexpected hash %h", out_bus.hash_value));
      end else begin
        want = expected_hashes.pop_front();
        if (out_bus.hash_value !== want)
          flag_error($sformatf("hash_value mismatch: expected %h, got %h",
                               want, out_bus.hash_value));
      end
    end
    out_bus.ready <= stall_free || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Offer one word, with a random idle gap in front, and hold until the transaction
  task automatic send_word(input key_word_t w);
    int gap;
    gap = 0;
    if (!stall_free && $urandom_range(99) < IDLE_PERCENT)
      gap = ($urandom_range(4) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.first_word  <= w.first_word;
    in_bus.key_length  <= w.key_length;
    in_bus.data_word   <= w.data_word;
    in_bus.valid_bytes <= w.valid_bytes;
    in_bus.last_word   <= w.last_word;
    in_bus.valid       <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    absorb_word(w);
  endtask

  // Drop valid and wait until every hash is back and the engine has gone idle
  task automatic settle_idle();
    in_bus.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    cfg_bus.hash_seed <= value;
    cfg_bus.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    seed_shadow = value;
  endtask

  // Stream one key of nbytes bytes; optionally lie about the length or drop the first flag
  task automatic send_key(input int nbytes, input bit honest_len, input bit drop_first,
                          output int n_words);
    key_word_t        w;
    logic [LEN_W-1:0] len_field;
    n_words   = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    len_field = honest_len ? LEN_W'(nbytes) : LEN_W'($urandom);
    for (int i = 0; i < n_words; i++) begin
      w.first_word = (i == 0) && !drop_first;
      w.key_length = (i == 0) ? len_field : LEN_W'($urandom);
      w.data_word  = rand64();
      w.last_word  = (i == n_words - 1);
      if (w.last_word) begin
        w.valid_bytes = VB_W'(nbytes - 8 * (n_words - 1));
        // oversize counts saturate to a full block
        if (w.valid_bytes == BYTES && $urandom_range(3) == 0)
          w.valid_bytes = VB_W'($urandom_range(9, 15));
      end else begin
        w.valid_bytes = ($urandom_range(3) == 0) ? VB_W'($urandom) : VB_W'(BYTES);
      end
      send_word(w);
    end
  endtask

  // Mostly well-formed keys of random size, plus broken keys and random noise words
  task automatic run_key_mix(input logic [63:0] seed, input int word_budget);
    int sent;
    int n;
    int nbytes;
    int pick;
    settle_idle();
    write_seed(seed);
    sent = 0;
    while (sent < word_budget) begin
      pick   = $urandom_range(99);
      nbytes = ($urandom_range(9) == 0) ? $urandom_range(41, 256) : $urandom_range(0, 40);
      if (pick < 80) begin
        send_key(nbytes, 1'b1, 1'b0, n);
      end else if (pick < 88) begin
        send_key(nbytes, 1'b0, 1'b0, n);
      end else if (pick < 94) begin
        send_key(nbytes, 1'b1, 1'b1, n);
      end else begin
        send_word(make_word(1'($urandom_range(1)), LEN_W'($urandom), rand64(),
                            VB_W'($urandom), 1'($urandom_range(1))));
        n = 1;
      end
      sent += n;
    end
  endtask

  // Edge cases under the reset seed: empty key, every tail count, broken streams
  task automatic test_directed_words();
    send_word(make_word(1'b1, '0, '0, 4'd0, 1'b1));
    send_word(make_word(1'b1, '1, '1, 4'd8, 1'b1));
    for (int vb = 1; vb < 16; vb++) begin
      if (vb != BYTES)
        send_word(make_word(1'b1, LEN_W'(vb), rand64(), VB_W'(vb), 1'b1));
    end
    // non-last words mix as full blocks whatever their count
    send_word(make_word(1'b1, LEN_W'(21), rand64(), 4'd3, 1'b0));
    send_word(make_word(1'b0, '0, rand64(), 4'd0, 1'b0));
    send_word(make_word(1'b0, '0, rand64(), 4'd5, 1'b1));
    // stream with no first word carries on from the held hash
    send_word(make_word(1'b0, 31'h5555_5555, rand64(), 4'd8, 1'b0));
    send_word(make_word(1'b0, 31'h2aaa_aaaa, rand64(), 4'd2, 1'b1));
    // declared length disagrees with the words streamed
    send_word(make_word(1'b1, LEN_W'(3), rand64(), 4'd8, 1'b0));
    send_word(make_word(1'b0, '0, rand64(), 4'd8, 1'b1));
  endtask

  task automatic test_seed_extremes();
    run_key_mix('1, 170);
    run_key_mix(64'h1, 170);
    run_key_mix(64'h8000_0000_0000_0000, 170);
    run_key_mix('0, 170);
  endtask

  task automatic test_random_seeds();
    run_key_mix(rand64(), 170);
    run_key_mix(rand64(), 170);
  endtask

  // Long stretch with both sides always ready
  task automatic test_back_to_back();
    stall_free = 1'b1;
    run_key_mix(rand64(), 150);
    settle_idle();
    stall_free = 1'b0;
  endtask

  initial begin
    seed_shadow         = '0;
    hash_state          = '0;
    error_count         = 0;
    stall_free          = 1'b0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.first_word   = 1'b0;
    in_bus.key_length   = '0;
    in_bus.data_word    = '0;
    in_bus.valid_bytes  = '0;
    in_bus.last_word    = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.hash_seed   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_words();
    test_seed_extremes();
    test_back_to_back();
    test_random_seeds();
    settle_idle();

    if (error_count == 0 && expected_hashes.size() == 0) begin
      $display("murmur_hash_64a_tb: done, clean");
    end else begin
      if (expected_hashes.size() != 0)
        $display("%0d expected hashes never arrived", expected_hashes.size());
      $display("murmur_hash_64a_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("murmur_hash_64a_tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
hdl/mmh64a_pkg.sv
hdl/mmh64a_in_if.sv
hdl/mmh64a_out_if.sv
hdl/mmh64a_cfg_if.sv
hdl/mmh64a_ctl.sv
hdl/mmh64a_dp.sv
hdl/murmur_hash_64a.sv
tb/murmur_hash_64a_tb.sv
